// File: rtl/core/i2cts_pkg.sv
// shared types and codes for the i2c master transfer sequencer
package i2cts_pkg;

    localparam int OP_SLOT_W = 3;
    localparam int SLOTS     = 2 ** OP_SLOT_W;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [3:0] ST_START    = 4'd0;
    localparam logic [3:0] ST_RESTART  = 4'd1;
    localparam logic [3:0] ST_ADDRW_ACK = 4'd2;
    localparam logic [3:0] ST_ADDRR_ACK = 4'd4;
    localparam logic [3:0] ST_TX_ACK   = 4'd6;
    localparam logic [3:0] ST_RX_ACK   = 4'd8;
    localparam logic [3:0] ST_RX_NAK   = 4'd9;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] ACK_KEEP    = 2'd0;
    localparam logic [1:0] ACK_ENABLE  = 2'd1;
    localparam logic [1:0] ACK_DISABLE = 2'd2;

    localparam logic [1:0] OUT_BUSY  = 2'd0;
    localparam logic [1:0] OUT_OK    = 2'd1;
    localparam logic [1:0] OUT_ERROR = 2'd2;

    localparam logic [8:0] IDX_MAX = 9'h1ff;

    typedef enum logic [1:0] {
        STG_START    = 2'd0,
        STG_ADDR     = 2'd1,
        STG_ADDR_ACK = 2'd2,
        STG_DATA     = 2'd3
    } stage_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] slave_address;
        logic [3:0] op_count;
        logic [2:0] op_slot;
        logic       op_is_read;
        logic [8:0] op_length;
        logic       status_valid;
        logic [3:0] status_code;
        logic [7:0] tx_data;
        logic [7:0] rx_data;
    } in_item_t;

    typedef struct packed {
        logic       issue_start;
        logic       repeated_start;
        logic [1:0] data_action;
        logic [7:0] data_byte;
        logic [2:0] op_index;
        logic [8:0] byte_index;
        logic [1:0] ack_control;
        logic       clear_flag;
        logic       issue_stop;
        logic [1:0] outcome;
    } result_t;

    typedef struct packed {
        logic       en;
        logic [2:0] slot;
        logic       is_read;
        logic [8:0] length;
    } tbl_wr_t;

    typedef struct packed {
        logic       is_read;
        logic [8:0] len;
    } desc_t;

endpackage

// File: rtl/core/i2c_master_transfer_sequencer.sv
// top level: input register, sequencer step, descriptor store, result register
// an input word passes input register, sequencer step and result register to the output
// throughput: one word per cycle unless a result stalls at the output
// a word that causes no result still passes the step stage
// reset: asynchronous, active low; idle, no request, descriptor store left unwritten
// output register parts sides: an empty input register takes input while a result waits
module i2c_master_transfer_sequencer #(
    parameter int MAX_OPS = 8,
    parameter int MAX_LEN = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slave_address, op_count, op_slot, op_is_read, op_length, status_valid,
    // status_code, tx_data, rx_data
    input  logic [47:0] s_tdata,
    // kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // issue_start, repeated_start, data_action, data_byte, op_index, byte_index,
    // ack_control, clear_flag, issue_stop, outcome
    output logic [31:0] m_tdata
);

    logic                in_vld_reg, in_vld_next;
    i2cts_pkg::in_item_t in_item_reg;
    logic                out_vld_reg, out_vld_next;
    i2cts_pkg::result_t  out_res_reg;

    i2cts_pkg::in_item_t in_item;
    logic                advance;
    logic                res_valid;
    i2cts_pkg::result_t  res;
    i2cts_pkg::desc_t    desc;
    i2cts_pkg::tbl_wr_t  tbl_wr;
    logic [3:0]          cur_op;

    assign in_item.kind          = s_tuser;
    assign in_item.slave_address = s_tdata[6:0];
    assign in_item.op_count      = s_tdata[10:7];
    assign in_item.op_slot       = s_tdata[13:11];
    assign in_item.op_is_read    = s_tdata[14];
    assign in_item.op_length     = s_tdata[23:15];
    assign in_item.status_valid  = s_tdata[24];
    assign in_item.status_code   = s_tdata[28:25];
    assign in_item.tx_data       = s_tdata[36:29];
    assign in_item.rx_data       = s_tdata[44:37];

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
        if (advance)
        begin
            out_vld_next = res_valid;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item;
        end
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    i2cts_op_table #(
        .MAX_OPS (MAX_OPS),
        .MAX_LEN (MAX_LEN)
    ) u_op_table (
        .clk   (clk),
        .wr    (tbl_wr),
        .rd_op (cur_op),
        .desc  (desc)
    );

    i2cts_seq #(
        .MAX_OPS (MAX_OPS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (in_item_reg),
        .desc      (desc),
        .cur_op    (cur_op),
        .tbl_wr    (tbl_wr),
        .res_valid (res_valid),
        .res       (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.outcome,
                       out_res_reg.issue_stop,
                       out_res_reg.clear_flag,
                       out_res_reg.ack_control,
                       out_res_reg.byte_index,
                       out_res_reg.op_index,
                       out_res_reg.data_byte,
                       out_res_reg.data_action,
                       out_res_reg.repeated_start,
                       out_res_reg.issue_start};

endmodule

// File: rtl/core/i2cts_op_table.sv
// operation descriptor store with clamped length on read
module i2cts_op_table #(
    parameter int MAX_OPS = 8,
    parameter int MAX_LEN = 256
) (
    input  logic              clk,
    input  i2cts_pkg::tbl_wr_t wr,
    input  logic [3:0]        rd_op,
    output i2cts_pkg::desc_t  desc
);

    // slots beyond the slot field can never be loaded
    localparam int TBL_DEPTH = (MAX_OPS < i2cts_pkg::SLOTS) ? MAX_OPS : i2cts_pkg::SLOTS;
    localparam int TIW       = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    logic [9:0]     entries_reg [TBL_DEPTH];
    logic [TIW-1:0] rd_idx;
    logic [9:0]     entry;
    logic [8:0]     len_raw;

    always_ff @(posedge clk)
    begin
        if (wr.en && (32'(wr.slot) < TBL_DEPTH))
        begin
            entries_reg[wr.slot[TIW-1:0]] <= {wr.is_read, wr.length};
        end
    end

    always_comb
    begin
        if (32'(rd_op) < TBL_DEPTH)
        begin
            rd_idx = rd_op[TIW-1:0];
        end
        else
        begin
            rd_idx = '0;
        end
        entry   = entries_reg[rd_idx];
        len_raw = entry[8:0];
        desc.is_read = entry[9];
        if (len_raw == 9'd0)
        begin
            desc.len = 9'd1;
        end
        else if (32'(len_raw) > MAX_LEN)
        begin
            desc.len = 9'(MAX_LEN);
        end
        else
        begin
            desc.len = len_raw;
        end
    end

endmodule

// File: rtl/core/i2cts_seq.sv
// request state and per-word step decode
module i2cts_seq #(
    parameter int MAX_OPS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  i2cts_pkg::in_item_t item,
    input  i2cts_pkg::desc_t    desc,
    output logic [3:0]          cur_op,
    output i2cts_pkg::tbl_wr_t  tbl_wr,
    output logic                res_valid,
    output i2cts_pkg::result_t  res
);

    logic              busy_reg, busy_next;
    i2cts_pkg::stage_t stage_reg, stage_next;
    logic [3:0]        op_reg, op_next;
    logic [8:0]        done_reg, done_next;
    logic [6:0]        addr_reg, addr_next;
    logic [3:0]        total_reg, total_next;

    logic       is_tick;
    logic       last_op;
    logic [8:0] done_inc;
    logic [8:0] done_inc2;
    logic [3:0] op_inc;
    logic [3:0] cnt_clamped;
    logic [3:0] exp_addr_ack;

    assign cur_op    = op_reg;
    assign is_tick   = fire && (item.kind == i2cts_pkg::KIND_TICK) && busy_reg;
    assign op_inc    = op_reg + 4'd1;
    assign last_op   = ({1'b0, op_reg} + 5'd1) >= {1'b0, total_reg};
    assign done_inc  = (done_reg == i2cts_pkg::IDX_MAX) ? done_reg : done_reg + 9'd1;
    assign done_inc2 = (done_inc == i2cts_pkg::IDX_MAX) ? done_inc : done_inc + 9'd1;
    assign exp_addr_ack = desc.is_read ? i2cts_pkg::ST_ADDRR_ACK : i2cts_pkg::ST_ADDRW_ACK;

    always_comb
    begin
        if (item.op_count == 4'd0)
        begin
            cnt_clamped = 4'd1;
        end
        else if (32'(item.op_count) > MAX_OPS)
        begin
            cnt_clamped = 4'(MAX_OPS);
        end
        else
        begin
            cnt_clamped = item.op_count;
        end
    end

    assign tbl_wr.en      = fire && (item.kind == i2cts_pkg::KIND_LOAD);
    assign tbl_wr.slot    = item.op_slot;
    assign tbl_wr.is_read = item.op_is_read;
    assign tbl_wr.length  = item.op_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            stage_reg <= i2cts_pkg::STG_START;
            op_reg    <= 4'd0;
            done_reg  <= 9'd0;
            addr_reg  <= 7'd0;
            total_reg <= 4'd1;
        end
        else
        begin
            busy_reg  <= busy_next;
            stage_reg <= stage_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
            addr_reg  <= addr_next;
            total_reg <= total_next;
        end
    end

    // next state
    always_comb
    begin
        busy_next  = busy_reg;
        stage_next = stage_reg;
        op_next    = op_reg;
        done_next  = done_reg;
        addr_next  = addr_reg;
        total_next = total_reg;
        if (fire && (item.kind == i2cts_pkg::KIND_BEGIN) && !busy_reg)
        begin
            busy_next  = 1'b1;
            stage_next = i2cts_pkg::STG_START;
            op_next    = 4'd0;
            done_next  = 9'd0;
            addr_next  = item.slave_address;
            total_next = cnt_clamped;
        end
        else if (is_tick)
        begin
            unique case (stage_reg)
                i2cts_pkg::STG_START:
                begin
                    stage_next = i2cts_pkg::STG_ADDR;
                end
                i2cts_pkg::STG_ADDR:
                begin
                    if (item.status_valid)
                    begin
                        if ((item.status_code == i2cts_pkg::ST_START) ||
                            (item.status_code == i2cts_pkg::ST_RESTART))
                        begin
                            stage_next = i2cts_pkg::STG_ADDR_ACK;
                        end
                        else
                        begin
                            busy_next = 1'b0;
                        end
                    end
                end
                i2cts_pkg::STG_ADDR_ACK:
                begin
                    if (item.status_valid)
                    begin
                        if (item.status_code == exp_addr_ack)
                        begin
                            stage_next = i2cts_pkg::STG_DATA;
                        end
                        else
                        begin
                            busy_next = 1'b0;
                        end
                    end
                end
                i2cts_pkg::STG_DATA:
                begin
                    if (item.status_valid)
                    begin
                        if (desc.is_read)
                        begin
                            if (item.status_code == i2cts_pkg::ST_RX_ACK)
                            begin
                                done_next = done_inc;
                            end
                            else if (item.status_code == i2cts_pkg::ST_RX_NAK)
                            begin
                                if (last_op)
                                begin
                                    busy_next = 1'b0;
                                end
                                else
                                begin
                                    done_next  = 9'd0;
                                    op_next    = op_inc;
                                    stage_next = i2cts_pkg::STG_START;
                                end
                            end
                            else
                            begin
                                busy_next = 1'b0;
                            end
                        end
                        else if (item.status_code != i2cts_pkg::ST_TX_ACK)
                        begin
                            busy_next = 1'b0;
                        end
                        else if ((done_inc == desc.len) && !last_op)
                        begin
                            done_next  = 9'd0;
                            op_next    = op_inc;
                            stage_next = i2cts_pkg::STG_START;
                        end
                        else
                        begin
                            if (done_inc == desc.len)
                            begin
                                busy_next = 1'b0;
                            end
                            done_next = done_inc;
                        end
                    end
                end
                default:
                begin
                    stage_next = stage_reg;
                end
            endcase
        end
    end

    // result word
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        res.op_index   = op_reg[2:0];
        res.byte_index = done_reg;
        if (is_tick)
        begin
            unique case (stage_reg)
                i2cts_pkg::STG_START:
                begin
                    res_valid          = 1'b1;
                    res.issue_start    = 1'b1;
                    res.repeated_start = (op_reg != 4'd0);
                end
                i2cts_pkg::STG_ADDR:
                begin
                    res_valid = item.status_valid;
                    if ((item.status_code == i2cts_pkg::ST_START) ||
                        (item.status_code == i2cts_pkg::ST_RESTART))
                    begin
                        res.data_action = i2cts_pkg::ACT_WRITE;
                        res.data_byte   = {addr_reg, desc.is_read};
                        res.clear_flag  = 1'b1;
                    end
                    else
                    begin
                        res.outcome = i2cts_pkg::OUT_ERROR;
                    end
                end
                i2cts_pkg::STG_ADDR_ACK:
                begin
                    res_valid = item.status_valid;
                    if (item.status_code != exp_addr_ack)
                    begin
                        res.outcome = i2cts_pkg::OUT_ERROR;
                    end
                    else if (desc.is_read)
                    begin
                        res.ack_control = (desc.len > 9'd1) ? i2cts_pkg::ACK_ENABLE
                                                            : i2cts_pkg::ACK_KEEP;
                        res.clear_flag  = 1'b1;
                    end
                    else
                    begin
                        // first write byte goes out with the address ack
                        res.data_action = i2cts_pkg::ACT_WRITE;
                        res.data_byte   = item.tx_data;
                        res.byte_index  = done_inc;
                        res.clear_flag  = 1'b1;
                    end
                end
                i2cts_pkg::STG_DATA:
                begin
                    res_valid = item.status_valid;
                    if (desc.is_read)
                    begin
                        if (item.status_code == i2cts_pkg::ST_RX_ACK)
                        begin
                            res.data_action = i2cts_pkg::ACT_READ;
                            res.data_byte   = item.rx_data;
                            res.ack_control = (done_reg == desc.len - 9'd1)
                                              ? i2cts_pkg::ACK_DISABLE : i2cts_pkg::ACK_KEEP;
                            res.clear_flag  = 1'b1;
                        end
                        else if (item.status_code == i2cts_pkg::ST_RX_NAK)
                        begin
                            res.data_action = i2cts_pkg::ACT_READ;
                            res.data_byte   = item.rx_data;
                            if (last_op)
                            begin
                                res.issue_stop = 1'b1;
                                res.outcome    = i2cts_pkg::OUT_OK;
                            end
                        end
                        else
                        begin
                            res.outcome = i2cts_pkg::OUT_ERROR;
                        end
                    end
                    else if (item.status_code != i2cts_pkg::ST_TX_ACK)
                    begin
                        res.outcome = i2cts_pkg::OUT_ERROR;
                    end
                    else if (done_inc == desc.len)
                    begin
                        if (last_op)
                        begin
                            res.byte_index = done_inc;
                            res.issue_stop = 1'b1;
                            res.outcome    = i2cts_pkg::OUT_OK;
                        end
                        else
                        begin
                            res.op_index   = op_inc[2:0];
                            res.byte_index = 9'd0;
                        end
                    end
                    else
                    begin
                        res.data_action = i2cts_pkg::ACT_WRITE;
                        res.data_byte   = item.tx_data;
                        res.byte_index  = done_inc2;
                        res.clear_flag  = 1'b1;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_op_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, op_reg} < {1'b0, total_reg}))
        else $error("operation index beyond request count");

    a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.outcome != i2cts_pkg::OUT_BUSY)) |=> !busy_reg)
        else $error("request ended but sequencer still busy");

    a_start_then_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.issue_start) |=> (stage_reg == i2cts_pkg::STG_ADDR))
        else $error("start word not followed by address stage");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !res_valid)
        else $error("result word while idle");
`endif

endmodule
